// File: hdl/chgw_pkg.sv
// Package: shared types and constants for the gift-wrap hull block.
package chgw_pkg;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_FEW  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD, S_SORT_RD, S_SORT_LD, S_SORT_CMP, S_SORT_WR, S_EMIT0, S_SRD_B,
		S_SRD_I, S_SRD_J, S_SMUL, S_SEVAL, S_CLOSE, S_OUT
	} state_t;
endpackage

// File: hdl/chgw_stream_if.sv
// Interface: valid/ready stream channel with generic payload.
interface chgw_stream_if #(parameter int W = 33);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/convex_hull_gift_wrap_top.sv
// Top level: point load, bubble sort in memory, gift-wrap search, result output.
// Load: one point per cycle. The last point starts the hull; no input is taken until it ends.
// Sort: bubble passes on y repeat until a pass makes no swap (up to N passes, N points stored), then point 0 is read.
// Wrap: a candidate is dropped at its first failing check. Fewer than three points: the
// sort and wrap are skipped and a single too-few result is output.
// Reset (arst_n low) clears count, flags and control; the memory is not cleared.
module convex_hull_gift_wrap_top
	import chgw_pkg::*;
#(
	parameter int MAX_POINTS = 32,
	parameter int COORD_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	chgw_stream_if.sink   pts,
	chgw_stream_if.source hull
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int C  = COORD_BITS;
	localparam int PW = 2 * C;
	localparam int DW = C + 1;
	localparam int MW = 2 * DW;

	state_t st_q, st_d;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [MAX_POINTS-1:0] flg_q;
	logic [AW-1:0] i_q, j_q;
	logic          sw_q;
	logic signed [C-1:0] bx_q, by_q, ix_q, iy_q, zx_q, zy_q;
	logic signed [DW-1:0] ax_q, ay_q, dx_q, dy_q;
	logic signed [MW-1:0] m1_q, m2_q;
	logic [C-1:0] ox_q, oy_q;
	logic         ol_q, done_q;
	logic [1:0]   os_q;

	logic          we;
	logic [AW-1:0] wa, ra;
	logic [PW-1:0] wd, rd;

	chgw_point_mem #(.DEPTH(MAX_POINTS), .AW(AW), .DW(PW)) u_mem (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
	);

	logic signed [C-1:0] rx, ry;
	assign rx = rd[PW-1:C];
	assign ry = rd[C-1:0];
	logic last_idx;
	assign last_idx = (CW'(j_q) == n_q - CW'(1));
	logic i_end;
	assign i_end = (CW'(i_q) == n_q - CW'(1));
	logic [1:0] stat;
	assign stat = ovf_q ? ST_OVERFLOW : ST_OK;
	logic full;
	assign full = (n_q == CW'(MAX_POINTS));
	logic few;
	assign few = ((full ? n_q : n_q + CW'(1)) < CW'(3));
	logic swap;
	assign swap = (ry < iy_q);
	logic bad;
	assign bad = (j_q != i_q) && (m1_q < m2_q);

	assign pts.ready = (st_q == S_LOAD);
	assign hull.valid = (st_q == S_OUT);
	assign hull.data = {ox_q, oy_q, ol_q, os_q};

	always_comb begin
		st_d = st_q;
		we = 1'b0;
		wa = j_q;
		wd = {ix_q, iy_q};
		ra = j_q;
		unique case (st_q)
			S_LOAD: begin
				we = pts.valid && !full;
				wa = n_q[AW-1:0];
				wd = pts.data[PW:1];
				ra = '0;
				if (pts.valid && pts.data[0])
					st_d = few ? S_OUT : S_SORT_RD;
			end
			S_SORT_RD: begin
				ra = '0;
				st_d = S_SORT_LD;
			end
			S_SORT_LD: begin
				ra = AW'(1);
				st_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				we = swap;
				wa = j_q - AW'(1);
				wd = {rx, ry};
				st_d = S_SORT_WR;
			end
			S_SORT_WR: begin
				we = 1'b1;
				wa = j_q;
				wd = {ix_q, iy_q};
				if (last_idx) begin
					ra = '0;
					st_d = sw_q ? S_SORT_RD : S_EMIT0;
				end else begin
					ra = j_q + AW'(1);
					st_d = S_SORT_CMP;
				end
			end
			S_EMIT0: st_d = S_OUT;
			S_SRD_B: begin
				ra = i_q;
				if (!flg_q[i_q]) st_d = S_SRD_I;
				else if (i_end) st_d = S_CLOSE;
			end
			S_SRD_I: begin
				ra = '0;
				st_d = S_SRD_J;
			end
			S_SRD_J: st_d = S_SMUL;
			S_SMUL:  st_d = S_SEVAL;
			S_SEVAL: begin
				ra = j_q + AW'(1);
				if (bad) st_d = i_end ? S_CLOSE : S_SRD_B;
				else if (last_idx) st_d = S_OUT;
				else st_d = S_SRD_J;
			end
			S_CLOSE: st_d = S_OUT;
			S_OUT:   if (hull.ready) st_d = done_q ? S_LOAD : S_SRD_B;
			default: st_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_LOAD;
		else st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; ovf_q <= 1'b0; flg_q <= '0; i_q <= '0; j_q <= '0;
			sw_q <= 1'b0; done_q <= 1'b0;
			bx_q <= '0; by_q <= '0; ix_q <= '0; iy_q <= '0; zx_q <= '0; zy_q <= '0;
			ax_q <= '0; ay_q <= '0; dx_q <= '0; dy_q <= '0; m1_q <= '0; m2_q <= '0;
			ox_q <= '0; oy_q <= '0; ol_q <= 1'b0; os_q <= ST_OK;
		end else begin
			case (st_q)
				S_LOAD: if (pts.valid) begin
					if (full) ovf_q <= 1'b1;
					else n_q <= n_q + CW'(1);
					if (pts.data[0] && few) begin
						ox_q <= '0; oy_q <= '0; ol_q <= 1'b1; os_q <= ST_TOO_FEW;
						done_q <= 1'b1;
					end
				end
				S_SORT_RD: sw_q <= 1'b0;
				S_SORT_LD: begin
					ix_q <= rx; iy_q <= ry; j_q <= AW'(1);
				end
				S_SORT_CMP: begin
					if (swap) sw_q <= 1'b1;
					else begin ix_q <= rx; iy_q <= ry; end
				end
				S_SORT_WR: if (!last_idx) j_q <= j_q + AW'(1);
				S_EMIT0: begin
					ox_q <= rx; oy_q <= ry; ol_q <= 1'b0; os_q <= stat;
					zx_q <= rx; zy_q <= ry; bx_q <= rx; by_q <= ry;
					flg_q <= MAX_POINTS'(1); done_q <= 1'b0;
				end
				S_SRD_B: if (flg_q[i_q] && !i_end) i_q <= i_q + AW'(1);
				S_SRD_I: begin
					ix_q <= rx; iy_q <= ry;
					ax_q <= DW'(rx) - DW'(bx_q);
					ay_q <= DW'(ry) - DW'(by_q);
					j_q <= '0;
				end
				S_SRD_J: begin
					dx_q <= DW'(rx) - DW'(ix_q);
					dy_q <= DW'(ry) - DW'(iy_q);
				end
				S_SMUL: begin
					m1_q <= ax_q * dy_q;
					m2_q <= ay_q * dx_q;
				end
				S_SEVAL: begin
					if (bad) begin
						if (!i_end) i_q <= i_q + AW'(1);
					end else if (last_idx) begin
						flg_q[i_q] <= 1'b1; bx_q <= ix_q; by_q <= iy_q;
						ox_q <= ix_q; oy_q <= iy_q; ol_q <= 1'b0; os_q <= stat;
					end else j_q <= j_q + AW'(1);
				end
				S_CLOSE: begin
					ox_q <= zx_q; oy_q <= zy_q; ol_q <= 1'b1; os_q <= stat;
					done_q <= 1'b1;
				end
				S_OUT: if (hull.ready) begin
					i_q <= '0;
					if (done_q) begin
						n_q <= '0; ovf_q <= 1'b0; flg_q <= '0; done_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: hdl/chgw_point_mem.sv
// Point memory: one write port, one registered read port.
module chgw_point_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: bench/convex_hull_gift_wrap_top_test.sv
// Testbench: convex_hull_gift_wrap_top, directed point sets plus random sets vs. a hull predictor.
module convex_hull_gift_wrap_top_test
	import chgw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 32;
	localparam int WDOG = 400000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} point_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic [1:0]         status;
	} vertex_t;

	typedef struct {
		point_t  pt;
		bit      typed;
		vertex_t want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;

	chgw_stream_if #(33) pts ();
	chgw_stream_if #(35) hull ();

	convex_hull_gift_wrap_top uut (.clk(clk), .arst_n(arst_n), .pts(pts), .hull(hull));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	row_t    rows[$];
	vertex_t hull_exp[$];
	point_t  set_pts[$];
	bit      set_ovf;
	int      fails;
	int      acc_idx;
	int      idle_cnt;
	bit      hold_req;
	bit      in_rdy_s, out_vld_s;
	vertex_t out_dat_s;

	always @(negedge clk) begin
		in_rdy_s  <= pts.ready;
		out_vld_s <= hull.valid;
		out_dat_s <= hull.data;
	end

	function automatic longint turn(longint bx, longint by, longint ix, longint iy,
		longint jx, longint jy);
		return (ix - bx) * (jy - iy) - (iy - by) * (jx - ix);
	endfunction

	function automatic void queue_vertex(vertex_t v);
		hull_exp.insert(hull_exp.size(), v);
	endfunction

	function automatic void wrap_hull(point_t s[$], bit ovf);
		longint  xs[NPTS];
		longint  ys[NPTS];
		longint  tx, ty;
		bit      used[NPTS];
		bit      swapped, found, ok;
		int      n, back;
		logic [1:0] st;
		n = s.size();
		if (n < 3) begin
			queue_vertex('{16'sd0, 16'sd0, 1'b1, ST_TOO_FEW});
			return;
		end
		st = ovf ? ST_OVERFLOW : ST_OK;
		for (int i = 0; i < n; i++) begin
			xs[i] = s[i].x;
			ys[i] = s[i].y;
			used[i] = 0;
		end
		do begin
			swapped = 0;
			for (int i = 0; i + 1 < n; i++)
				if (ys[i+1] < ys[i]) begin
					tx = xs[i]; ty = ys[i];
					xs[i] = xs[i+1]; ys[i] = ys[i+1];
					xs[i+1] = tx; ys[i+1] = ty;
					swapped = 1;
				end
		end while (swapped);
		used[0] = 1;
		back = 0;
		queue_vertex('{xs[0][15:0], ys[0][15:0], 1'b0, st});
		do begin
			found = 0;
			for (int i = 0; i < n && !found; i++) begin
				if (used[i]) continue;
				ok = 1;
				for (int j = 0; j < n; j++)
					if (j != i && turn(xs[back], ys[back], xs[i], ys[i], xs[j], ys[j]) < 0)
						ok = 0;
				if (ok) begin
					used[i] = 1;
					back = i;
					queue_vertex('{xs[i][15:0], ys[i][15:0], 1'b0, st});
					found = 1;
				end
			end
		end while (found);
		queue_vertex('{xs[0][15:0], ys[0][15:0], 1'b1, st});
	endfunction

	function automatic void add_row(int x, int y, bit last);
		row_t r;
		r.pt = '{x[15:0], y[15:0], last};
		r.typed = 0;
		r.want = '0;
		rows.insert(rows.size(), r);
	endfunction

	function automatic void add_too_few(int x, int y);
		row_t r;
		r.pt = '{x[15:0], y[15:0], 1'b1};
		r.typed = 1;
		r.want = '{16'sd0, 16'sd0, 1'b1, ST_TOO_FEW};
		rows.insert(rows.size(), r);
	endfunction

	function automatic int rnd_coord(int mode);
		case (mode)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 16) - 8;
			2: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $urandom_range(0, 400) - 200;
		endcase
	endfunction

	task automatic build_stimulus();
		int n, mode;
		// directed
		add_too_few(5, 5);
		add_row(-32768, -32768, 0);
		add_too_few(32767, 32767);
		add_row(-32768, -32768, 0);
		add_row(32767, -32768, 0);
		add_row(0, 32767, 1);
		add_row(32767, 32767, 0);
		add_row(-32768, 32767, 0);
		add_row(32767, -32768, 0);
		add_row(-32768, -32768, 1);
		add_row(0, 0, 0);
		add_row(1, 1, 0);
		add_row(2, 2, 1);
		add_row(3, 3, 0);
		add_row(3, 3, 0);
		add_row(3, 3, 1);
		add_row(0, 0, 0);
		add_row(4, 0, 0);
		add_row(2, 1, 0);
		add_row(4, 4, 0);
		add_row(0, 4, 0);
		add_row(2, 0, 1);
		// random sets
		while (rows.size() < 205) begin
			case ($urandom_range(0, 19))
				0:       n = $urandom_range(1, 2);
				1:       n = $urandom_range(33, 36);
				2, 3:    n = $urandom_range(9, 16);
				default: n = $urandom_range(3, 8);
			endcase
			mode = (n > 16) ? 1 : $urandom_range(0, 3);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 30) == 0)
					add_row(rnd_coord(2), rnd_coord(2), k == n - 1);
				else
					add_row(rnd_coord(mode), rnd_coord(mode), k == n - 1);
			end
		end
	endtask

	initial begin
		int burst, gap;
		pts.valid = 0;
		pts.data = '0;
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int idx = 0; idx < rows.size(); ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && idx < rows.size(); b++) begin
				pts.valid <= 1;
				pts.data <= rows[idx].pt;
				@(posedge clk);
				while (!in_rdy_s) @(posedge clk);
				idx++;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0 || idx >= rows.size()) begin
				pts.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		while (acc_idx < rows.size() || hull_exp.size() > 0) @(posedge clk);
		repeat (20000) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver: stall pattern changes at random, one long hold-off
	initial begin
		int mode;
		bit held;
		held = 0;
		mode = 0;
		hull.ready = 0;
		forever begin
			if (hold_req && !held) begin
				held = 1;
				hull.ready <= 0;
				repeat (3000) @(posedge clk);
			end else begin
				if ($urandom_range(0, 399) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: hull.ready <= 1;
					1: hull.ready <= ($urandom_range(0, 3) != 0);
					default: hull.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		vertex_t w;
		if (arst_n && pts.valid && in_rdy_s) begin
			if (set_pts.size() < NPTS) set_pts.insert(set_pts.size(), rows[acc_idx].pt);
			else set_ovf = 1;
			if (rows[acc_idx].pt.last) begin
				if (rows[acc_idx].typed) queue_vertex(rows[acc_idx].want);
				else wrap_hull(set_pts, set_ovf);
				set_pts.delete();
				set_ovf = 0;
			end
			acc_idx++;
			if (acc_idx == 60) hold_req = 1;
		end
		if (arst_n && out_vld_s && hull.ready) begin
			if (hull_exp.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_dat_s);
				fails++;
			end else begin
				w = hull_exp.pop_front();
				if (w.x !== out_dat_s.x || w.y !== out_dat_s.y || w.last !== out_dat_s.last ||
					w.status !== out_dat_s.status) begin
					$display("%0t: expected x=%0d y=%0d l=%0d s=%0d got x=%0d y=%0d l=%0d s=%0d",
						$time, w.x, w.y, w.last, w.status,
						out_dat_s.x, out_dat_s.y, out_dat_s.last, out_dat_s.status);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pts.valid && in_rdy_s) || (out_vld_s && hull.ready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial idle_cnt = 0;
endmodule
